@@ hdl/ncc_pkg.sv @@
// ncc_pkg: shared constants, command and register codes, and interface types
// for the template-matching block. No dependencies.
`default_nettype none
package ncc_pkg;

  localparam int MAX_IMG_W = 256;
  localparam int MAX_IMG_H = 256;
  localparam int MAX_TPL_W = 16;
  localparam int MAX_TPL_H = 16;
  localparam int TPL_CW    = $clog2(MAX_TPL_W);
  localparam int TPL_RW    = $clog2(MAX_TPL_H);

  // Q0.16 gray weights (0.299, 0.587, 0.114)
  localparam logic [15:0] GRAY_WR = 16'd19595;
  localparam logic [15:0] GRAY_WG = 16'd38470;
  localparam logic [15:0] GRAY_WB = 16'd7471;

  // Q1.14 unity
  localparam logic [14:0] CORR_ONE = 15'd16384;

  localparam logic [1:0] CMD_LOAD_TPL = 2'd0;
  localparam logic [1:0] CMD_LOAD_IMG = 2'd1;
  localparam logic [1:0] CMD_EVAL     = 2'd2;

  localparam logic [2:0] CFG_TPL_W  = 3'd0;
  localparam logic [2:0] CFG_TPL_H  = 3'd1;
  localparam logic [2:0] CFG_IMG_W  = 3'd2;
  localparam logic [2:0] CFG_IMG_H  = 3'd3;
  localparam logic [2:0] CFG_THRESH = 3'd4;
  localparam logic [2:0] CFG_COLOR  = 3'd5;

  typedef struct packed {
    logic       en;
    logic       img;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] gray;
  } st_wr_t;

  typedef struct packed {
    logic [15:0] si;
    logic [15:0] st;
    logic [23:0] sii;
    logic [23:0] stt;
    logic [23:0] sit;
  } sums_t;

  typedef struct packed {
    logic       go;
    logic [1:0] word;
  } mul_req_t;

  typedef struct packed {
    logic       vld;
    logic [1:0] word;
  } mul_rsp_t;

endpackage
`default_nettype wire

@@ hdl/ncc_accum.sv @@
// ncc_accum: image and template stores plus the window sum pass
// (sums, sums of squares, cross sum). Depends on ncc_pkg.
`default_nettype none
module ncc_accum (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire ncc_pkg::st_wr_t wr,
  input  wire logic           start,
  input  wire logic [7:0]     row0,
  input  wire logic [7:0]     col0,
  input  wire logic [4:0]     tw,
  input  wire logic [4:0]     th,
  output logic                done,
  output ncc_pkg::sums_t      sums
);

  logic [7:0] img_mem [0:ncc_pkg::MAX_IMG_W*ncc_pkg::MAX_IMG_H-1];
  logic [7:0] tpl_mem [0:ncc_pkg::MAX_TPL_W*ncc_pkg::MAX_TPL_H-1];

  logic                       busy_r, v1_r, last1_r, done_r;
  logic [ncc_pkg::TPL_RW-1:0] i_r;
  logic [ncc_pkg::TPL_CW-1:0] j_r;
  logic [7:0]                 p_r, t_r;
  logic [15:0]                img_addr;
  logic [ncc_pkg::TPL_RW+ncc_pkg::TPL_CW-1:0] tpl_addr;
  logic [ncc_pkg::TPL_CW-1:0] tw_m1;
  logic [ncc_pkg::TPL_RW-1:0] th_m1;
  logic                       last_issue;
  logic                       tpl_in;
  logic [4:0]                 tw_d, th_d;

  assign tw_d       = tw - 5'd1;
  assign th_d       = th - 5'd1;
  assign tw_m1      = tw_d[ncc_pkg::TPL_CW-1:0];
  assign th_m1      = th_d[ncc_pkg::TPL_RW-1:0];
  assign last_issue = (i_r == th_m1) && (j_r == tw_m1);
  assign img_addr   = {row0 + 8'(i_r), col0 + 8'(j_r)};
  assign tpl_addr   = {i_r, j_r};
  assign tpl_in     = (wr.row < 8'(ncc_pkg::MAX_TPL_H)) && (wr.col < 8'(ncc_pkg::MAX_TPL_W));

  always_ff @(posedge clk) begin
    if (wr.en && wr.img) begin
      img_mem[{wr.row, wr.col}] <= wr.gray;
    end
    if (wr.en && !wr.img && tpl_in) begin
      tpl_mem[{wr.row[ncc_pkg::TPL_RW-1:0], wr.col[ncc_pkg::TPL_CW-1:0]}] <= wr.gray;
    end
    p_r <= img_mem[img_addr];
    t_r <= tpl_mem[tpl_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      v1_r    <= 1'b0;
      last1_r <= 1'b0;
      done_r  <= 1'b0;
      i_r     <= '0;
      j_r     <= '0;
    end else begin
      done_r  <= v1_r && last1_r;
      v1_r    <= busy_r;
      last1_r <= busy_r && last_issue;
      if (start) begin
        busy_r <= 1'b1;
        i_r    <= '0;
        j_r    <= '0;
      end else if (busy_r) begin
        if (last_issue) begin
          busy_r <= 1'b0;
        end else if (j_r == tw_m1) begin
          j_r <= '0;
          i_r <= i_r + 1'b1;
        end else begin
          j_r <= j_r + 1'b1;
        end
      end
    end
  end

  // accumulate the pixel pair read last cycle
  always_ff @(posedge clk) begin
    if (start) begin
      sums <= '0;
    end else if (v1_r) begin
      sums.si  <= sums.si + 16'(p_r);
      sums.st  <= sums.st + 16'(t_r);
      sums.sii <= sums.sii + 24'(p_r * p_r);
      sums.stt <= sums.stt + 24'(t_r * t_r);
      sums.sit <= sums.sit + 24'(p_r * t_r);
    end
  end

  assign done = done_r;

endmodule
`default_nettype wire

@@ hdl/ncc_mul.sv @@
// ncc_mul: shared 32x32 unsigned multiplier with a registered product and
// word tag. Depends on ncc_pkg.
`default_nettype none
module ncc_mul (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ncc_pkg::mul_req_t req,
  input  wire logic [31:0]      a,
  input  wire logic [31:0]      b,
  output ncc_pkg::mul_rsp_t     rsp,
  output logic [63:0]           p
);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsp <= '0;
    end else begin
      rsp.vld  <= req.go;
      rsp.word <= req.word;
    end
  end

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule
`default_nettype wire

@@ hdl/ncc_solve.sv @@
// ncc_solve: sequencer that forms the variance and covariance terms and runs
// the exact binary search for the Q1.14 correlation on the shared multiplier.
// Depends on ncc_pkg and ncc_mul.
`default_nettype none
module ncc_solve (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [8:0]    n,
  input  wire ncc_pkg::sums_t sums,
  output logic               done,
  output logic               valid,
  output logic [15:0]        corr
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_POST} state_t;
  typedef enum logic [3:0] {
    ST_NSII, ST_SISI, ST_NSTT, ST_STST, ST_NSIT, ST_SIST, ST_AB, ST_NN,
    ST_LNN, ST_MM, ST_KK, ST_RKK, ST_MID2, ST_CMP
  } step_t;

  state_t        state_r;
  step_t         step_r, op_step;
  logic [95:0]   x_r, op_x;
  logic [31:0]   y_r, op_y;
  logic [1:0]    nw_r, wi_r, op_nw;
  logic [127:0]  acc_r, sh;
  logic [33:0]   t0_r;
  logic [31:0]   a_r, b_r, mag_r;
  logic          neg_r;
  logic [95:0]   l_r;
  logic [127:0]  r_r;
  logic [14:0]   lo_r, hi_r, mid_r, lo_n, hi_n, mid_n;
  logic [15:0]   mid_sum;
  logic          fin, fin_valid, search;
  logic [34:0]   cdiff;
  logic [8:0]    n_m1;
  logic          done_r, valid_r;
  logic [15:0]   corr_r;

  ncc_pkg::mul_req_t req;
  ncc_pkg::mul_rsp_t rsp;
  logic [63:0]       prod;

  ncc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .a     (x_r[{wi_r, 5'd0} +: 32]),
    .b     (y_r),
    .rsp   (rsp),
    .p     (prod)
  );

  assign req.go   = (state_r == S_MUL) && (wi_r < nw_r);
  assign req.word = wi_r;
  assign n_m1     = n - 9'd1;
  assign cdiff    = {1'b0, t0_r} - {1'b0, acc_r[33:0]};

  always_comb begin
    case (rsp.word)
      2'd0:    sh = {64'd0, prod};
      2'd1:    sh = {32'd0, prod, 32'd0};
      2'd2:    sh = {prod, 64'd0};
      default: sh = {prod[31:0], 96'd0};
    endcase
  end

  // pick the next operation once the current product is complete
  always_comb begin
    op_step   = step_r;
    op_x      = '0;
    op_y      = '0;
    op_nw     = 2'd1;
    fin       = 1'b0;
    fin_valid = 1'b0;
    search    = 1'b0;
    lo_n      = lo_r;
    hi_n      = hi_r;
    mid_sum   = '0;
    mid_n     = mid_r;
    case (step_r)
      ST_NSII: begin
        op_step = ST_SISI; op_x = 96'(sums.si); op_y = 32'(sums.si);
      end
      ST_SISI: begin
        op_step = ST_NSTT; op_x = 96'(sums.stt); op_y = 32'(n);
      end
      ST_NSTT: begin
        op_step = ST_STST; op_x = 96'(sums.st); op_y = 32'(sums.st);
      end
      ST_STST: begin
        op_step = ST_NSIT; op_x = 96'(sums.sit); op_y = 32'(n);
      end
      ST_NSIT: begin
        op_step = ST_SIST; op_x = 96'(sums.si); op_y = 32'(sums.st);
      end
      ST_SIST: begin
        if (a_r == '0 || b_r == '0) begin
          fin = 1'b1;
        end
        op_step = ST_AB; op_x = 96'(a_r); op_y = b_r;
      end
      ST_AB: begin
        op_step = ST_NN; op_x = 96'(n); op_y = 32'(n);
      end
      ST_NN: begin
        op_step = ST_LNN; op_x = {32'd0, l_r[63:0]}; op_y = acc_r[31:0]; op_nw = 2'd2;
      end
      ST_LNN: begin
        op_step = ST_MM; op_x = 96'(mag_r); op_y = mag_r;
      end
      ST_MM: begin
        op_step = ST_KK; op_x = 96'(n_m1); op_y = 32'(n_m1);
      end
      ST_KK: begin
        op_step = ST_RKK; op_x = {32'd0, r_r[63:0]}; op_y = acc_r[31:0]; op_nw = 2'd2;
      end
      ST_RKK: begin
        lo_n = '0; hi_n = ncc_pkg::CORR_ONE; search = 1'b1;
      end
      ST_MID2: begin
        op_step = ST_CMP; op_x = l_r; op_y = acc_r[31:0]; op_nw = 2'd3;
      end
      ST_CMP: begin
        if (acc_r <= r_r) begin
          lo_n = mid_r;
        end else begin
          hi_n = mid_r - 15'd1;
        end
        search = 1'b1;
      end
      default: fin = 1'b1;
    endcase
    if (search) begin
      if (lo_n == hi_n) begin
        fin       = 1'b1;
        fin_valid = 1'b1;
      end else begin
        mid_sum = 16'(lo_n) + 16'(hi_n) + 16'd1;
        mid_n   = mid_sum[15:1];
        op_step = ST_MID2;
        op_x    = 96'(mid_n);
        op_y    = 32'(mid_n);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
      step_r  <= ST_NSII;
      wi_r    <= '0;
      nw_r    <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            step_r  <= ST_NSII;
            x_r     <= 96'(sums.sii);
            y_r     <= 32'(n);
            nw_r    <= 2'd1;
            wi_r    <= '0;
            acc_r   <= '0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          if (req.go) begin
            wi_r <= wi_r + 2'd1;
          end
          if (rsp.vld) begin
            acc_r <= acc_r + sh;
          end else if (wi_r == nw_r) begin
            state_r <= S_POST;
          end
        end
        S_POST: begin
          case (step_r)
            ST_NSII, ST_NSTT, ST_NSIT: t0_r <= acc_r[33:0];
            ST_SISI: a_r <= 32'(t0_r - acc_r[33:0]);
            ST_STST: b_r <= 32'(t0_r - acc_r[33:0]);
            ST_SIST: begin
              neg_r <= cdiff[34];
              mag_r <= cdiff[34] ? 32'(-cdiff) : cdiff[31:0];
            end
            ST_AB, ST_LNN: l_r <= acc_r[95:0];
            ST_MM:         r_r <= acc_r;
            ST_RKK:        r_r <= acc_r << 28;
            default: ;
          endcase
          lo_r  <= lo_n;
          hi_r  <= hi_n;
          mid_r <= mid_n;
          if (fin) begin
            done_r  <= 1'b1;
            valid_r <= fin_valid;
            corr_r  <= fin_valid ? (neg_r ? -{1'b0, lo_n} : {1'b0, lo_n}) : 16'd0;
            state_r <= S_IDLE;
          end else begin
            step_r  <= op_step;
            x_r     <= op_x;
            y_r     <= op_y;
            nw_r    <= op_nw;
            wi_r    <= '0;
            acc_r   <= '0;
            state_r <= S_MUL;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign done  = done_r;
  assign valid = valid_r;
  assign corr  = corr_r;

endmodule
`default_nettype wire

@@ hdl/ncc_template_match_window.sv @@
// ncc_template_match_window: top level with configuration registers, gray
// conversion, command decode, result register. Depends on ncc_pkg,
// ncc_accum and ncc_solve.
//
//   channel | ports          | transaction
//   --------+----------------+---------------------------------------------
//   input   | in_t*          | one command: load template/image pixel, eval
//   result  | out_t*         | one window result per evaluate command
//   config  | cfg_we/addr/.. | one register write, no back-pressure
//
// A load leaves the input ready for the next command. An evaluate runs the
// sum pass over the stores, then the setup products and 14 or 15 search steps
// on the shared 32x32 multiplier; a zero-variance window skips the search,
// and an out-of-bounds window skips both the sum pass and the solve. Reset
// (rst_n low, synchronous) restores register defaults; stores are not
// cleared. in_tready is low while an evaluate runs and while its result
// waits for a free output register.
`default_nettype none
module ncc_template_match_window (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // row[7:0], col[15:8], blue[23:16],
                                       // green[31:24], red[39:32]
  input  wire logic [1:0]  in_tuser,   // command[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // window_row[7:0], window_col[15:8],
                                       // correlation[31:16], is_match[32],
                                       // window_valid[33], match_color[57:34]
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [23:0] cfg_wdata
);

  typedef enum logic [1:0] {T_IDLE, T_ACC, T_SOLVE, T_HOLD} state_t;

  state_t       state_r;
  logic [4:0]   tw_r, th_r;
  logic [8:0]   iw_r, ih_r;
  logic [15:0]  thr_r;
  logic [23:0]  color_r;
  logic [7:0]   row_r, col_r;
  logic [8:0]   n_r;
  logic         res_valid_r;
  logic [15:0]  res_corr_r;
  logic         out_valid_r;
  logic [63:0]  out_data_r;

  logic         accept, is_eval, geo_ok, out_free, acc_start, acc_done;
  logic [8:0]   iw_eff, ih_eff;
  logic [23:0]  gray_sum;
  logic [7:0]   in_row, in_col, in_b, in_g, in_r;
  logic         is_match;
  logic         solve_done, solve_valid;
  logic [15:0]  solve_corr;
  ncc_pkg::st_wr_t wr;
  ncc_pkg::sums_t  sums;

  assign in_row = in_tdata[7:0];
  assign in_col = in_tdata[15:8];
  assign in_b   = in_tdata[23:16];
  assign in_g   = in_tdata[31:24];
  assign in_r   = in_tdata[39:32];

  assign in_tready = (state_r == T_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign is_eval   = (in_tuser == ncc_pkg::CMD_EVAL);
  assign out_free  = !out_valid_r || out_tready;

  // gray = (wr*R + wg*G + wb*B) >> 16, weights sum to one in Q0.16
  assign gray_sum = 24'(in_r * ncc_pkg::GRAY_WR) + 24'(in_g * ncc_pkg::GRAY_WG)
                  + 24'(in_b * ncc_pkg::GRAY_WB);

  assign wr.en   = accept && ((in_tuser == ncc_pkg::CMD_LOAD_TPL) ||
                              (in_tuser == ncc_pkg::CMD_LOAD_IMG));
  assign wr.img  = (in_tuser == ncc_pkg::CMD_LOAD_IMG);
  assign wr.row  = in_row;
  assign wr.col  = in_col;
  assign wr.gray = gray_sum[23:16];

  // clamp image size to the store; zero leaves every window out of bounds
  assign iw_eff = (iw_r > 9'(ncc_pkg::MAX_IMG_W)) ? 9'(ncc_pkg::MAX_IMG_W) : iw_r;
  assign ih_eff = (ih_r > 9'(ncc_pkg::MAX_IMG_H)) ? 9'(ncc_pkg::MAX_IMG_H) : ih_r;

  assign geo_ok = (tw_r != 5'd0) && (th_r != 5'd0)
               && (tw_r <= 5'(ncc_pkg::MAX_TPL_W)) && (th_r <= 5'(ncc_pkg::MAX_TPL_H))
               && ((10'(in_row) + 10'(th_r)) <= 10'(ih_eff))
               && ((10'(in_col) + 10'(tw_r)) <= 10'(iw_eff));

  assign acc_start = accept && is_eval && geo_ok;

  ncc_accum u_accum (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (wr),
    .start (acc_start),
    .row0  (row_r),
    .col0  (col_r),
    .tw    (tw_r),
    .th    (th_r),
    .done  (acc_done),
    .sums  (sums)
  );

  ncc_solve u_solve (
    .clk   (clk),
    .rst_n (rst_n),
    .start ((state_r == T_ACC) && acc_done),
    .n     (n_r),
    .sums  (sums),
    .done  (solve_done),
    .valid (solve_valid),
    .corr  (solve_corr)
  );

  assign is_match = res_valid_r && ($signed(res_corr_r) >= $signed(thr_r));

  // configuration writes land at once; issue them only while no transaction
  // is in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tw_r    <= 5'd11;
      th_r    <= 5'd15;
      iw_r    <= 9'd256;
      ih_r    <= 9'd256;
      thr_r   <= 16'd8192;
      color_r <= 24'd0;
    end else if (cfg_we) begin
      case (cfg_addr)
        ncc_pkg::CFG_TPL_W:  tw_r    <= cfg_wdata[4:0];
        ncc_pkg::CFG_TPL_H:  th_r    <= cfg_wdata[4:0];
        ncc_pkg::CFG_IMG_W:  iw_r    <= cfg_wdata[8:0];
        ncc_pkg::CFG_IMG_H:  ih_r    <= cfg_wdata[8:0];
        ncc_pkg::CFG_THRESH: thr_r   <= cfg_wdata[15:0];
        ncc_pkg::CFG_COLOR:  color_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // drop valid once taken; T_HOLD reloads the register on its own
      if (out_valid_r && out_tready && (state_r != T_HOLD)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        T_IDLE: begin
          if (accept && is_eval) begin
            row_r <= in_row;
            col_r <= in_col;
            n_r   <= 9'(tw_r * th_r);
            if (geo_ok) begin
              state_r <= T_ACC;
            end else begin
              res_valid_r <= 1'b0;
              res_corr_r  <= 16'd0;
              state_r     <= T_HOLD;
            end
          end
        end
        T_ACC: begin
          if (acc_done) begin
            state_r <= T_SOLVE;
          end
        end
        T_SOLVE: begin
          if (solve_done) begin
            res_valid_r <= solve_valid;
            res_corr_r  <= solve_corr;
            state_r     <= T_HOLD;
          end
        end
        T_HOLD: begin
          // hold the result until the output register frees up
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {6'd0, color_r, res_valid_r, is_match, res_corr_r,
                            col_r, row_r};
            state_r     <= T_IDLE;
          end
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

@@ bench/ncc_template_match_window_tb.sv @@
// Self-checking bench for ncc_template_match_window: loads both pixel stores,
// evaluates windows under several register settings, checks each result against
// an exact predictor of the correlation. Depends on ncc_pkg and the block RTL.
`timescale 1ns / 100ps
`default_nettype none

module ncc_template_match_window_tb;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 2000;
  localparam int DRAIN_CYCLES = 450;

  // One evaluate result, packed so that row lands in the low bits.
  typedef struct packed {
    logic [23:0] color;
    logic        valid;
    logic        match;
    logic [15:0] corr;
    logic [7:0]  col;
    logic [7:0]  row;
  } window_result_t;

  // Mirror of both stores and the registers; predicts one result per evaluate.
  class ncc_scoreboard;
    logic [7:0] img_px[65536];
    bit         img_set[65536];
    logic [7:0] tpl_px[256];
    bit         tpl_set[256];
    int unsigned tpl_w, tpl_h, img_w, img_h;
    logic [15:0] thresh;
    logic [23:0] color;
    window_result_t expected_q[$];
    int mismatches, results_seen, valid_seen, match_seen;

    function new();
      tpl_w = 11;
      tpl_h = 15;
      img_w = 256;
      img_h = 256;
      thresh = 16'd8192;
      color = '0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] val);
      case (idx)
        ncc_pkg::CFG_TPL_W:  tpl_w = val[4:0];
        ncc_pkg::CFG_TPL_H:  tpl_h = val[4:0];
        ncc_pkg::CFG_IMG_W:  img_w = val[8:0];
        ncc_pkg::CFG_IMG_H:  img_h = val[8:0];
        ncc_pkg::CFG_THRESH: thresh = val[15:0];
        ncc_pkg::CFG_COLOR:  color = val;
        default: ;
      endcase
    endfunction

    // True when the window reads nothing, or reads only written pixels.
    function bit window_readable(int row, int col);
      int iw, ih;
      iw = (img_w < ncc_pkg::MAX_IMG_W) ? img_w : ncc_pkg::MAX_IMG_W;
      ih = (img_h < ncc_pkg::MAX_IMG_H) ? img_h : ncc_pkg::MAX_IMG_H;
      if (tpl_w < 1 || tpl_h < 1 || tpl_w > ncc_pkg::MAX_TPL_W ||
          tpl_h > ncc_pkg::MAX_TPL_H || row + tpl_h > ih || col + tpl_w > iw)
        return 1;
      for (int i = 0; i < tpl_h; i++)
        for (int j = 0; j < tpl_w; j++)
          if (!img_set[(row + i) * ncc_pkg::MAX_IMG_W + col + j] ||
              !tpl_set[i * ncc_pkg::MAX_TPL_W + j])
            return 0;
      return 1;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void note_input(logic [1:0] cmd, logic [39:0] data);
      logic [7:0] row, col, gray;
      int unsigned v;
      int iw, ih;
      longint unsigned n, si, st, sii, stt, sit, a, b, p, t, k, mag, lo, hi, mid;
      longint c;
      logic [191:0] wm, wk, wa, wb, wq, rhs, lhs;
      window_result_t res;
      row = data[7:0];
      col = data[15:8];
      v = 19595 * data[39:32] + 38470 * data[31:24] + 7471 * data[23:16];
      gray = v[23:16];
      case (cmd)
        ncc_pkg::CMD_LOAD_TPL: begin
          if (row < ncc_pkg::MAX_TPL_H && col < ncc_pkg::MAX_TPL_W) begin
            tpl_px[row * ncc_pkg::MAX_TPL_W + col] = gray;
            tpl_set[row * ncc_pkg::MAX_TPL_W + col] = 1;
          end
        end
        ncc_pkg::CMD_LOAD_IMG: begin
          img_px[row * ncc_pkg::MAX_IMG_W + col] = gray;
          img_set[row * ncc_pkg::MAX_IMG_W + col] = 1;
        end
        ncc_pkg::CMD_EVAL: begin
          iw = (img_w < ncc_pkg::MAX_IMG_W) ? img_w : ncc_pkg::MAX_IMG_W;
          ih = (img_h < ncc_pkg::MAX_IMG_H) ? img_h : ncc_pkg::MAX_IMG_H;
          res.row = row;
          res.col = col;
          res.corr = '0;
          res.valid = 0;
          res.color = color;
          if (tpl_w >= 1 && tpl_h >= 1 && tpl_w <= ncc_pkg::MAX_TPL_W &&
              tpl_h <= ncc_pkg::MAX_TPL_H && row + tpl_h <= ih && col + tpl_w <= iw) begin
            n = tpl_w * tpl_h;
            si = 0; st = 0; sii = 0; stt = 0; sit = 0;
            for (int i = 0; i < tpl_h; i++)
              for (int j = 0; j < tpl_w; j++) begin
                p = img_px[(row + i) * ncc_pkg::MAX_IMG_W + col + j];
                t = tpl_px[i * ncc_pkg::MAX_TPL_W + j];
                si += p; st += t; sii += p * p; stt += t * t; sit += p * t;
              end
            a = n * sii - si * si;
            b = n * stt - st * st;
            c = longint'(n * sit) - longint'(si * st);
            if (a != 0 && b != 0) begin
              // Largest q with (q*n)^2 * A*B <= (16384*(n-1))^2 * C^2.
              mag = (c < 0) ? 0 - c : c;
              k = 16384 * (n - 1);
              wm = mag; wk = k; wa = a; wb = b;
              rhs = wm * wm * wk * wk;
              lo = 0;
              hi = 16384;
              while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                wq = mid * n;
                lhs = wa * wb * wq * wq;
                if (lhs <= rhs) lo = mid;
                else hi = mid - 1;
              end
              res.corr = (c < 0) ? 16'(0 - lo) : 16'(lo);
              res.valid = 1;
            end
          end
          res.match = res.valid && ($signed(res.corr) >= $signed(thresh));
          expected_q.push_back(res);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [63:0] data);
      window_result_t got, exp;
      got = data[57:0];
      results_seen++;
      if (expected_q.size() == 0) begin
        flag($sformatf("unexpected result: row %0d col %0d corr %0d",
                       got.row, got.col, $signed(got.corr)));
        return;
      end
      exp = expected_q.pop_front();
      valid_seen += exp.valid;
      match_seen += exp.match;
      if (got.row !== exp.row || got.col !== exp.col || got.corr !== exp.corr ||
          got.match !== exp.match || got.valid !== exp.valid || got.color !== exp.color)
        flag($sformatf({"result mismatch: exp row %0d col %0d corr %0d match %0b ",
                        "valid %0b color %06h / got row %0d col %0d corr %0d match %0b ",
                        "valid %0b color %06h"},
                       exp.row, exp.col, $signed(exp.corr), exp.match, exp.valid,
                       exp.color, got.row, got.col, $signed(got.corr), got.match,
                       got.valid, got.color));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // row[7:0], col[15:8], blue[23:16], green[31:24], red[39:32]
  logic [1:0]  in_tuser;   // command[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // window_row[7:0], window_col[15:8], correlation[31:16],
                           // is_match[32], window_valid[33], match_color[57:34]
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [23:0] cfg_wdata;

  ncc_scoreboard sb;
  int  burst_left;
  bit  hold_req;
  int  idle_cycles;
  int  settings_used;
  logic [7:0] tpl_gray[256];

  always #2 clk = ~clk;

  ncc_template_match_window dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // Observe both channels at the rising edge; feed the predictor and the checker.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_input(in_tuser, in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Watchdog: count cycles with no transaction on any channel.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Receiver: switch between stall patterns; on request, hold off once for a
  // long stretch so the block backs up into its input.
  initial begin
    int mode, mode_left;
    bit hold_done;
    mode = 0;
    mode_left = 0;
    hold_done = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1;
        out_tready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(8, 80);
        end
        mode_left--;
        case (mode)
          0: out_tready = 1'b1;
          1: out_tready = ($urandom_range(0, 3) != 0);
          default: out_tready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Offer one transaction; idle for a random gap first when a burst runs out.
  task automatic send_item(input logic [1:0] cmd, input logic [7:0] row, col, b, g, r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
      repeat (gap) begin
        @(negedge clk);
        in_tvalid = 1'b0;
      end
      burst_left = $urandom_range(1, 16);
    end
    @(negedge clk);
    in_tuser = cmd;
    in_tdata = {r, g, b, col, row};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    burst_left--;
  endtask

  task automatic gray_px(input logic [1:0] cmd, input logic [7:0] row, col, v);
    send_item(cmd, row, col, v, v, v);
  endtask

  task automatic eval_at(input logic [7:0] row, col);
    send_item(ncc_pkg::CMD_EVAL, row, col, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Drop valid and wait until every expected result is out, plus a margin
  // for a trailing load.
  task automatic settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [2:0] idx, input logic [23:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic config_all(input int tw, th, iw, ih, input logic [15:0] thr,
                            input logic [23:0] color);
    settle();
    write_cfg(ncc_pkg::CFG_TPL_W, 24'(tw));
    write_cfg(ncc_pkg::CFG_TPL_H, 24'(th));
    write_cfg(ncc_pkg::CFG_IMG_W, 24'(iw));
    write_cfg(ncc_pkg::CFG_IMG_H, 24'(ih));
    write_cfg(ncc_pkg::CFG_THRESH, {8'h00, thr});
    write_cfg(ncc_pkg::CFG_COLOR, color);
    @(negedge clk);
    cfg_we = 1'b0;
    settings_used++;
  endtask

  task automatic random_config();
    int tw, th, iw, ih;
    logic [15:0] thr;
    tw = $urandom_range(1, 16);
    th = $urandom_range(1, 16);
    if ($urandom_range(0, 7) == 0) tw = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(17, 31);
    case ($urandom_range(0, 3))
      0: iw = 256;
      1: iw = 511;
      2: iw = $urandom_range(0, 511);
      default: iw = $urandom_range(16, 256);
    endcase
    ih = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 511) : 256;
    case ($urandom_range(0, 2))
      0: thr = 16'($urandom);
      1: thr = 16'(0 - $urandom_range(0, 16384));
      default: thr = 16'($urandom_range(0, 16384));
    endcase
    config_all(tw, th, iw, ih, thr, 24'($urandom));
  endtask

  // Pick a window position, favoring the filled regions; fall back to the
  // top-left corner, which is always readable.
  task automatic random_eval();
    int r, c;
    for (int tries = 0; tries < 16; tries++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin r = $urandom_range(0, 23); c = $urandom_range(0, 23); end
        5, 6, 7:       begin r = $urandom_range(232, 255); c = $urandom_range(232, 255); end
        default:       begin r = $urandom_range(0, 255); c = $urandom_range(0, 255); end
      endcase
      if (sb.window_readable(r, c)) begin
        eval_at(8'(r), 8'(c));
        return;
      end
    end
    eval_at(8'd0, 8'd0);
  endtask

  task automatic random_item();
    int sel, r, c;
    sel = $urandom_range(0, 99);
    if (sel < 38) begin
      random_eval();
    end else if (sel < 75) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin r = $urandom_range(0, 23); c = $urandom_range(0, 23); end
        5, 6:          begin r = $urandom_range(240, 255); c = $urandom_range(240, 255); end
        default:       begin r = $urandom_range(0, 255); c = $urandom_range(0, 255); end
      endcase
      send_item(ncc_pkg::CMD_LOAD_IMG, 8'(r), 8'(c), 8'($urandom), 8'($urandom),
                8'($urandom));
    end else if (sel < 92) begin
      if ($urandom_range(0, 4) == 0) begin
        r = $urandom_range(0, 255); c = $urandom_range(0, 255);
      end else begin
        r = $urandom_range(0, 15); c = $urandom_range(0, 15);
      end
      send_item(ncc_pkg::CMD_LOAD_TPL, 8'(r), 8'(c), 8'($urandom), 8'($urandom),
                8'($urandom));
    end else begin
      send_item(CMD_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom));
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    burst_left = 0;
    hold_req = 0;
    settings_used = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Fill the whole template with gray pixels (r = g = b keeps gray exact).
    for (int i = 0; i < 256; i++) begin
      tpl_gray[i] = 8'($urandom);
      gray_px(ncc_pkg::CMD_LOAD_TPL, 8'(i / 16), 8'(i % 16), tpl_gray[i]);
    end
    // Top-left 16x16: a copy of the template; a flat 4x4 patch just below-right.
    for (int r = 0; r < 16; r++)
      for (int c = 0; c < 16; c++)
        gray_px(ncc_pkg::CMD_LOAD_IMG, 8'(r), 8'(c), tpl_gray[r * 16 + c]);
    for (int i = 0; i < 16; i++)
      gray_px(ncc_pkg::CMD_LOAD_IMG, 8'(16 + i / 4), 8'(16 + i % 4), 8'd100);
    // Bottom-right 8x8: the inverted template corner, flush against the image edge.
    for (int i = 0; i < 64; i++)
      gray_px(ncc_pkg::CMD_LOAD_IMG, 8'(248 + i / 8), 8'(248 + i % 8),
              8'd255 - tpl_gray[(i / 8) * 16 + i % 8]);

    // Directed: reset settings, then template size and image size extremes.
    eval_at(8'd0, 8'd0);                 // exact copy
    eval_at(8'd242, 8'd246);             // runs past the bottom edge
    send_item(CMD_UNUSED, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    send_item(ncc_pkg::CMD_LOAD_TPL, 8'd20, 8'd3, 8'h00, 8'h00, 8'h00);  // outside store
    send_item(ncc_pkg::CMD_LOAD_TPL, 8'd3, 8'd16, 8'h00, 8'h00, 8'h00);
    config_all(16, 16, 256, 256, 16'sd16384, 24'hffffff);
    eval_at(8'd0, 8'd0);
    eval_at(8'd241, 8'd240);             // one row too low
    config_all(8, 8, 256, 256, 16'sd8192, 24'h0000ff);
    eval_at(8'd248, 8'd248);             // inverted copy at the corner
    eval_at(8'd0, 8'd0);
    config_all(4, 4, 256, 256, -16'sd16384, 24'h000000);
    eval_at(8'd16, 8'd16);               // flat image window
    eval_at(8'd252, 8'd252);
    config_all(1, 1, 256, 256, 16'sd0, 24'h5a5a5a);
    eval_at(8'd255, 8'd255);             // single pixel: no variance
    config_all(0, 3, 256, 256, 16'sd0, 24'h123456);
    eval_at(8'd0, 8'd0);                 // zero template width
    config_all(31, 17, 256, 256, 16'sd0, 24'h654321);
    eval_at(8'd0, 8'd0);                 // oversized template
    config_all(2, 2, 0, 0, 16'sd0, 24'h00ff00);
    eval_at(8'd0, 8'd0);                 // zero image size
    config_all(2, 2, 511, 300, 16'h8000, 24'hff0000);
    // Flat template corner: template variance is zero.
    for (int i = 0; i < 4; i++)
      gray_px(ncc_pkg::CMD_LOAD_TPL, 8'(i / 2), 8'(i % 2), 8'd77);
    eval_at(8'd2, 8'd2);

    // Random part: several settings, each with a run of mixed transactions.
    for (int ph = 0; ph < 6; ph++) begin
      random_config();
      for (int i = 0; i < 23; i++) begin
        if (ph == 2 && i == 5) hold_req = 1;
        random_item();
      end
    end

    // Drain: every expectation met, then give the block time to misbehave.
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d window results (%0d valid, %0d matches) over %0d register settings",
             sb.results_seen, sb.valid_seen, sb.match_seen, settings_used + 1);
    $display("mismatches counted: %0d", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
hdl/ncc_pkg.sv
hdl/ncc_accum.sv
hdl/ncc_mul.sv
hdl/ncc_solve.sv
hdl/ncc_template_match_window.sv
bench/ncc_template_match_window_tb.sv
